@@ hdl/bsh_pkg.sv @@
// Package with constants and hash step functions for the byte stream hash.
`default_nettype none

package bsh_pkg;

  localparam int HASH_W = 64;
  localparam int BYTE_W = 8;
  localparam int MAX_STRING_CHARS_DEF = 1000;

  localparam logic MODE_SIZED  = 1'b0;
  localparam logic MODE_STRING = 1'b1;

  localparam int OAT_SHL   = 10;
  localparam int OAT_SHR   = 6;
  localparam int FIN_SHL_A = 3;
  localparam int FIN_SHR   = 11;
  localparam int FIN_SHL_B = 15;
  localparam int MUL_SHL   = 5;

  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [BYTE_W-1:0] byte_t;

  function automatic hash_t sext_byte(input byte_t b);
    sext_byte = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
  endfunction

  function automatic hash_t oat_step(input hash_t h, input hash_t v);
    hash_t a;
    hash_t m;
    a = h + v;
    m = a + (a << OAT_SHL);
    oat_step = m ^ (m >> OAT_SHR);
  endfunction

  function automatic hash_t mul31_step(input hash_t h, input hash_t v);
    hash_t s;
    s = (h << MUL_SHL) - h + v;
    mul31_step = (s == '1) ? '0 : s;
  endfunction

  function automatic hash_t final_mix_a(input hash_t h);
    hash_t a;
    a = h + (h << FIN_SHL_A);
    final_mix_a = a ^ (a >> FIN_SHR);
  endfunction

  function automatic hash_t final_mix_b(input hash_t h);
    final_mix_b = h + (h << FIN_SHL_B);
  endfunction

endpackage

`default_nettype wire

@@ hdl/byte_stream_hash_two_mode_top.sv @@
// Top level of the two-mode byte stream hash with its pipeline and running state.
`default_nettype none

// The block takes one message byte per cycle while in_stall is low and keeps a
// 64-bit running hash. In sized mode (cfg 0) it runs the one-at-a-time hash
// and applies the final mix after the byte flagged as last. In string mode
// (cfg 1) it computes hash * 31 + byte, a zero byte or the byte flagged as last
// ends the message (a zero byte without being hashed), and bytes past
// MAX_STRING_CHARS are ignored. Bytes are sign-extended before use. The
// running-hash register is updated once per accepted byte. The hash of a
// finished message passes the input register, the result register and the two
// final-mix stages before it appears at the output; while a result waits to be
// taken, the pipeline keeps accepting bytes until its result stages are full.

module byte_stream_hash_two_mode_top #(
  parameter int MAX_STRING_CHARS = bsh_pkg::MAX_STRING_CHARS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic                      cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [bsh_pkg::BYTE_W-1:0] in_data_byte,
  input  wire logic                      in_end_of_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [bsh_pkg::HASH_W-1:0]     out_hash_value
);

  localparam int CntW = $clog2(MAX_STRING_CHARS + 1);

  logic                mode_r;
  logic                s0_v_r;
  bsh_pkg::byte_t      s0_byte_r;
  logic                s0_last_r;
  logic                s0_mode_r;
  bsh_pkg::hash_t      hash_r;
  bsh_pkg::hash_t      hash_nxt;
  logic [CntW-1:0]     cnt_r;
  logic [CntW-1:0]     cnt_nxt;
  logic                r1_v_r;
  bsh_pkg::hash_t      r1_hash_r;
  logic                r1_mix_r;
  logic                r2_v_r;
  bsh_pkg::hash_t      r2_hash_r;
  logic                r2_mix_r;
  logic                out_valid_r;
  bsh_pkg::hash_t      out_hash_r;

  logic                rdy1;
  logic                rdy2;
  logic                rdy3;
  logic                fire1;
  logic                done;
  logic                res_mix;
  bsh_pkg::hash_t      res_hash;
  bsh_pkg::hash_t      byte_ext;
  bsh_pkg::hash_t      upd_hash;

  assign rdy3  = !out_valid_r || !out_stall;
  assign rdy2  = !r2_v_r || rdy3;
  assign rdy1  = !r1_v_r || rdy2;
  assign fire1 = s0_v_r && rdy1;

  assign in_stall       = s0_v_r && !rdy1;
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  assign byte_ext = bsh_pkg::sext_byte(s0_byte_r);

  always_comb begin
    hash_nxt = hash_r;
    cnt_nxt  = cnt_r;
    done     = 1'b0;
    res_mix  = 1'b0;
    res_hash = hash_r;
    upd_hash = hash_r;
    if (s0_mode_r == bsh_pkg::MODE_SIZED) begin
      upd_hash = bsh_pkg::oat_step(hash_r, byte_ext);
      hash_nxt = upd_hash;
      res_hash = upd_hash;
      res_mix  = 1'b1;
      done     = s0_last_r;
    end else if (s0_byte_r == '0) begin
      done = 1'b1;
    end else begin
      if (cnt_r < CntW'(MAX_STRING_CHARS)) begin
        upd_hash = bsh_pkg::mul31_step(hash_r, byte_ext);
        hash_nxt = upd_hash;
        cnt_nxt  = cnt_r + CntW'(1);
      end
      res_hash = upd_hash;
      done     = s0_last_r;
    end
    if (done) begin
      hash_nxt = '0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bsh_pkg::MODE_SIZED;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (!s0_v_r || rdy1) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!s0_v_r || rdy1) && in_valid) begin
      s0_byte_r <= in_data_byte;
      s0_last_r <= in_end_of_data;
      s0_mode_r <= mode_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
      cnt_r  <= '0;
    end else if (fire1) begin
      hash_r <= hash_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r      <= 1'b0;
      r2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        r1_v_r <= fire1 && done;
      end
      if (rdy2) begin
        r2_v_r <= r1_v_r;
      end
      if (rdy3) begin
        out_valid_r <= r2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      r1_hash_r <= res_hash;
      r1_mix_r  <= res_mix;
    end
    if (rdy2) begin
      r2_hash_r <= r1_mix_r ? bsh_pkg::final_mix_a(r1_hash_r) : r1_hash_r;
      r2_mix_r  <= r1_mix_r;
    end
    if (rdy3) begin
      out_hash_r <= r2_mix_r ? bsh_pkg::final_mix_b(r2_hash_r) : r2_hash_r;
    end
  end

  a_clear_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    fire1 && done |=> hash_r == '0 && cnt_r == '0)
    else $error("running hash not cleared after message end");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MAX_STRING_CHARS))
    else $error("character count beyond limit");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    r2_v_r && !rdy3 |=> r2_v_r && $stable(r2_hash_r))
    else $error("mix stage lost a result under stall");

  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !fire1 |=> $stable(hash_r) && $stable(cnt_r))
    else $error("running state changed without an item");

endmodule

`default_nettype wire
